// ===== rtl/psar_pkg.sv =====
// Shared constants and register codes for the parabolic stop-and-reverse block.
package psar_pkg;

  localparam int PRICE_WIDTH_DEF      = 32;
  localparam int FACTOR_FRAC_BITS_DEF = 16;

  // Register reset values, unsigned Q0.16 at the default factor width.
  localparam int AF_STEP_RESET  = 1311;
  localparam int AF_LIMIT_RESET = 13107;

  localparam int CFG_INDEX_WIDTH = 1;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_AF_STEP  = 1'b0,
    REG_AF_LIMIT = 1'b1
  } cfg_reg_t;

endpackage

// ===== rtl/parabolic_stop_and_reverse.sv =====
// Top level of the parabolic stop-and-reverse indicator over a stream of price bars.
//
// Usage:
// Each input transaction (in_valid/in_ready) carries one price bar: bar_high, bar_low
// and series_start. Each output transaction (out_valid/out_ready) carries exactly one
// result per bar, in order: stop_level and rising_trend after that bar.
// A bar with series_start set restarts the series: the result is the bar's low with
// an up trend. Bars that follow move the stop toward the extreme point.
// From acceptance to out_valid a bar passes through the input register, then through
// the update logic into the state registers, which also hold the result.
// Throughput is one bar per cycle while the receiver keeps up; the single loop that
// sets it is the state recurrence (one multiply, an add with saturation, clamps and
// a reversal compare). When the receiver stalls, the result is held and one more bar
// waits in the input register; in_ready falls only while both are full.
// Reset clears both registers, restores the trend state to an up trend with zero
// factor, stop, extreme and prior bar, and loads af_step and af_limit with defaults.
// The registers are written with cfg_write, cfg_index and cfg_data, by the user only
// while idle (the block does not enforce this), and take effect from the next bar.
module parabolic_stop_and_reverse #(
  parameter int PRICE_WIDTH      = psar_pkg::PRICE_WIDTH_DEF,
  parameter int FACTOR_FRAC_BITS = psar_pkg::FACTOR_FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_write,
  input  logic [psar_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [FACTOR_FRAC_BITS-1:0]             cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [PRICE_WIDTH-1:0]           bar_high,
  input  logic signed [PRICE_WIDTH-1:0]           bar_low,
  input  logic                                    series_start,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [PRICE_WIDTH-1:0]           stop_level,
  output logic                                    rising_trend
);
  import psar_pkg::*;

  localparam int PW = PRICE_WIDTH;
  localparam int FW = FACTOR_FRAC_BITS;

  // Configuration registers.
  logic [FW-1:0] af_step;
  logic [FW-1:0] af_limit;

  // Input register.
  logic                 s1_valid;
  logic signed [PW-1:0] s1_high;
  logic signed [PW-1:0] s1_low;
  logic                 s1_start;

  // Indicator state; the stop and trend registers are also the result register.
  logic                 trend_up;
  logic        [FW:0]   accel_factor;
  logic signed [PW-1:0] stop_value;
  logic signed [PW-1:0] extreme_point;
  logic signed [PW-1:0] last_high;
  logic signed [PW-1:0] last_low;

  logic                 trend_up_next;
  logic        [FW:0]   accel_factor_next;
  logic signed [PW-1:0] stop_value_next;
  logic signed [PW-1:0] extreme_point_next;
  logic signed [PW-1:0] moved;

  logic in_fire;
  logic advance;

  // The bar in the input register moves on whenever the result slot is free or
  // is being emptied in this cycle.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;
  assign in_fire  = in_valid && in_ready;

  assign stop_level   = stop_value;
  assign rising_trend = trend_up;

  psar_move #(
    .PRICE_WIDTH      (PW),
    .FACTOR_FRAC_BITS (FW)
  ) u_move (
    .prior   (stop_value),
    .extreme (extreme_point),
    .factor  (accel_factor),
    .moved   (moved)
  );

  psar_update #(
    .PRICE_WIDTH      (PW),
    .FACTOR_FRAC_BITS (FW)
  ) u_update (
    .start        (s1_start),
    .bar_hi       (s1_high),
    .bar_lo       (s1_low),
    .prev_hi      (last_high),
    .prev_lo      (last_low),
    .trend        (trend_up),
    .factor       (accel_factor),
    .prior        (stop_value),
    .extreme      (extreme_point),
    .moved        (moved),
    .step         (af_step),
    .limit        (af_limit),
    .trend_next   (trend_up_next),
    .factor_next  (accel_factor_next),
    .stop_next    (stop_value_next),
    .extreme_next (extreme_point_next)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      af_step  <= FW'(AF_STEP_RESET);
      af_limit <= FW'(AF_LIMIT_RESET);
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_AF_STEP:  af_step  <= cfg_data;
        REG_AF_LIMIT: af_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input register: control bit under reset, payload loaded on acceptance.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_high  <= bar_high;
      s1_low   <= bar_low;
      s1_start <= series_start;
    end
  end

  // State and result registers, updated once per bar.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      trend_up      <= 1'b1;
      accel_factor  <= '0;
      stop_value    <= '0;
      extreme_point <= '0;
      last_high     <= '0;
      last_low      <= '0;
    end else if (advance) begin
      out_valid     <= 1'b1;
      trend_up      <= trend_up_next;
      accel_factor  <= accel_factor_next;
      stop_value    <= stop_value_next;
      extreme_point <= extreme_point_next;
      last_high     <= s1_high;
      last_low      <= s1_low;
    end else if (out_ready) begin
      out_valid     <= 1'b0;
    end
  end

endmodule

// ===== rtl/psar_move.sv =====
// Moves the stop toward the extreme point by the acceleration factor, with saturation.
module psar_move #(
  parameter int PRICE_WIDTH      = psar_pkg::PRICE_WIDTH_DEF,
  parameter int FACTOR_FRAC_BITS = psar_pkg::FACTOR_FRAC_BITS_DEF
) (
  input  logic signed [PRICE_WIDTH-1:0]    prior,
  input  logic signed [PRICE_WIDTH-1:0]    extreme,
  input  logic        [FACTOR_FRAC_BITS:0] factor,
  output logic signed [PRICE_WIDTH-1:0]    moved
);
  import psar_pkg::*;

  localparam int PW    = PRICE_WIDTH;
  localparam int FW    = FACTOR_FRAC_BITS;
  localparam int AW    = FW + 1;
  localparam int PRODW = PW + AW;
  localparam int QW    = PRODW - FW;
  localparam int SW    = PW + 3;

  logic signed [PW:0]    diff;
  logic                  going_down;
  logic        [PW-1:0]  mag;
  logic        [PRODW-1:0] prod;
  logic        [QW-1:0]  qmag;
  logic signed [SW-1:0]  prior_ext;
  logic signed [SW-1:0]  qmag_ext;
  logic signed [SW-1:0]  sum;
  logic                  fits;

  always_comb begin
    diff       = {extreme[PW-1], extreme} - {prior[PW-1], prior};
    going_down = diff[PW];
    mag        = going_down ? PW'(-diff) : PW'(diff);
    // Exact product; dropping the fraction bits rounds the magnitude toward zero.
    prod       = PRODW'(mag) * PRODW'(factor);
    qmag       = prod[PRODW-1:FW];
    prior_ext  = $signed({{(SW-PW){prior[PW-1]}}, prior});
    qmag_ext   = $signed({{(SW-QW){1'b0}}, qmag});
    sum        = going_down ? (prior_ext - qmag_ext) : (prior_ext + qmag_ext);
    // The sum fits the price range when the price sign bit and all bits above it agree.
    fits       = (sum[SW-1:PW-1] == {(SW-PW+1){1'b0}}) ||
                 (sum[SW-1:PW-1] == {(SW-PW+1){1'b1}});
    if (fits) begin
      moved = sum[PW-1:0];
    end else if (sum[SW-1]) begin
      moved = {1'b1, {(PW-1){1'b0}}};
    end else begin
      moved = {1'b0, {(PW-1){1'b1}}};
    end
  end

endmodule

// ===== rtl/psar_update.sv =====
// Trend, factor, extreme point and stop update for one bar.
module psar_update #(
  parameter int PRICE_WIDTH      = psar_pkg::PRICE_WIDTH_DEF,
  parameter int FACTOR_FRAC_BITS = psar_pkg::FACTOR_FRAC_BITS_DEF
) (
  input  logic                             start,
  input  logic signed [PRICE_WIDTH-1:0]    bar_hi,
  input  logic signed [PRICE_WIDTH-1:0]    bar_lo,
  input  logic signed [PRICE_WIDTH-1:0]    prev_hi,
  input  logic signed [PRICE_WIDTH-1:0]    prev_lo,
  input  logic                             trend,
  input  logic        [FACTOR_FRAC_BITS:0] factor,
  input  logic signed [PRICE_WIDTH-1:0]    prior,
  input  logic signed [PRICE_WIDTH-1:0]    extreme,
  input  logic signed [PRICE_WIDTH-1:0]    moved,
  input  logic        [FACTOR_FRAC_BITS-1:0] step,
  input  logic        [FACTOR_FRAC_BITS-1:0] limit,
  output logic                             trend_next,
  output logic        [FACTOR_FRAC_BITS:0] factor_next,
  output logic signed [PRICE_WIDTH-1:0]    stop_next,
  output logic signed [PRICE_WIDTH-1:0]    extreme_next
);
  import psar_pkg::*;

  localparam int PW = PRICE_WIDTH;
  localparam int AW = FACTOR_FRAC_BITS + 1;

  logic        [AW-1:0] step_ext;
  logic        [AW-1:0] factor_grown;
  logic                 new_ext;
  logic signed [PW-1:0] ext_mid;
  logic        [AW-1:0] factor_mid;
  logic signed [PW-1:0] bound;
  logic signed [PW-1:0] cand;
  logic signed [PW-1:0] held;

  always_comb begin
    step_ext     = {1'b0, step};
    factor_grown = (factor < {1'b0, limit}) ? (factor + step_ext) : factor;
    new_ext      = trend ? (bar_hi > extreme) : (bar_lo < extreme);
    ext_mid      = new_ext ? (trend ? bar_hi : bar_lo) : extreme;
    factor_mid   = new_ext ? factor_grown : factor;
    if (trend) begin
      // Up trend: stay below the two latest lows but never fall back.
      bound = (bar_lo < prev_lo) ? bar_lo : prev_lo;
      cand  = (bound < moved) ? bound : moved;
      held  = (cand > prior) ? cand : prior;
    end else begin
      // Down trend: stay above the two latest highs but never rise back.
      bound = (bar_hi > prev_hi) ? bar_hi : prev_hi;
      cand  = (bound > moved) ? bound : moved;
      held  = (cand < prior) ? cand : prior;
    end

    if (start) begin
      trend_next   = 1'b1;
      factor_next  = step_ext;
      stop_next    = bar_lo;
      extreme_next = bar_hi;
    end else if (trend && (bar_lo < held)) begin
      trend_next   = 1'b0;
      factor_next  = step_ext;
      stop_next    = ext_mid;
      extreme_next = bar_lo;
    end else if (!trend && (bar_hi > held)) begin
      trend_next   = 1'b1;
      factor_next  = step_ext;
      stop_next    = ext_mid;
      extreme_next = bar_hi;
    end else begin
      trend_next   = trend;
      factor_next  = factor_mid;
      stop_next    = held;
      extreme_next = ext_mid;
    end
  end

endmodule

// ===== rtl/psar_checker.sv =====
// Port-level assertions for the stop-and-reverse block, bound to its top level.
module psar_checker #(
  parameter int PRICE_WIDTH = psar_pkg::PRICE_WIDTH_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [PRICE_WIDTH-1:0] stop_level,
  input logic                   rising_trend
);
  import psar_pkg::*;

  // No result may be offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

  // A stalled result holds its value.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(stop_level) &&
                                   $stable(rising_trend)))
    else $error("stalled result changed or dropped");

  // The input side only stalls while a result is waiting and the receiver stalls.
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input not ready without an output stall");

  // A bar accepted on an idle block reaches out_valid via the input and state registers.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !out_valid && $past(!in_valid || !in_ready) &&
     !$past(rst)) |=> ##1 out_valid)
    else $error("result missing two cycles after acceptance");

endmodule

bind parabolic_stop_and_reverse psar_checker #(
  .PRICE_WIDTH (PRICE_WIDTH)
) u_psar_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .stop_level   (stop_level),
  .rising_trend (rising_trend)
);
